FILE: sv/taylor_sine_cosine_macros.svh
// Assertion macros shared by the Taylor sine/cosine RTL.
`ifndef TAYLOR_SINE_COSINE_MACROS_SVH
`define TAYLOR_SINE_COSINE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define TSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/tsc_pkg.sv
// Types, widths and constants for the Taylor sine/cosine block.
package tsc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ANGLE_W   = 32;
  localparam int XSQ_W     = 35;                  // (|x|*|x|) >> 28, up to 2^34
  localparam int MAG_W     = 62;                  // |fact + acc| < 2^62
  localparam int HALF_W    = 31;                  // multiplier slice of MAG_W
  localparam int MUL_W     = ANGLE_W + XSQ_W;     // 32 x 35 product
  localparam int PROD_W    = 97;                  // MAG_W + XSQ_W
  localparam int FIN_W     = PROD_W - FRAC_BITS;  // product after the Q28 shift
  localparam int TERMS_W   = 5;
  localparam logic [TERMS_W-1:0] TERMS_RESET = 5'd8;

  localparam int DIV_W     = 12;                  // largest divisor 2*31*63
  localparam int DIV_CELLS = 8;                   // quotient bits per cycle
  localparam int DIVD_W    = 72;
  localparam int DIV_STEPS = DIVD_W / DIV_CELLS;
  localparam int CNT_W     = 4;

  localparam logic [MAG_W-1:0]    ACC_CAP = 62'h2000_0000_0000_0000;
  localparam logic signed [63:0]  ACC_LIM = 64'sh2000_0000_0000_0000;
  localparam logic signed [63:0]  ONE_Q   = 64'sh1000_0000;
  localparam logic [ANGLE_W-1:0]  POS_MAX = 32'h7FFF_FFFF;
  localparam logic [ANGLE_W-1:0]  NEG_MIN = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_SQ_W,
    S_PREP,
    S_MLO,
    S_MHI,
    S_MADD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } tsc_state_e;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } tsc_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } tsc_div_rsp_t;

  // Horner divisor: 2m(2m+1) for sine, 2m(2m-1) for cosine.
  function automatic logic [DIV_W-1:0] div_const(logic cosine, logic [TERMS_W-1:0] m);
    logic [DIV_W-1:0] mm;
    logic [DIV_W-1:0] odd;
    mm  = DIV_W'(m);
    odd = cosine ? ((mm << 1) - DIV_W'(1)) : ((mm << 1) + DIV_W'(1));
    return (mm * odd) << 1;
  endfunction

endpackage

FILE: sv/tsc_div_cell.sv
// One restoring-division cell: takes one dividend bit, yields one quotient bit.
module tsc_div_cell (
  input  logic [tsc_pkg::DIV_W-1:0] rem_i,
  input  logic                      bit_i,
  input  logic [tsc_pkg::DIV_W-1:0] divisor_i,
  output logic [tsc_pkg::DIV_W-1:0] rem_o,
  output logic                      qbit_o
);

  logic [tsc_pkg::DIV_W:0] trial;
  logic [tsc_pkg::DIV_W:0] diff;

  assign trial  = {rem_i, bit_i};
  assign diff   = trial - {1'b0, divisor_i};
  assign qbit_o = (trial >= {1'b0, divisor_i});
  // rem_i < divisor, so the kept value always fits the remainder width
  assign rem_o  = qbit_o ? diff[tsc_pkg::DIV_W-1:0] : trial[tsc_pkg::DIV_W-1:0];

endmodule

FILE: sv/tsc_divider.sv
// Chain of division cells: DIV_CELLS quotient bits per cycle, dividend MSB first.
module tsc_divider (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsc_pkg::tsc_div_req_t req_i,
  output tsc_pkg::tsc_div_rsp_t rsp_o
);

  logic [tsc_pkg::DIVD_W-1:0]    dvd_q;
  logic [tsc_pkg::DIVD_W-1:0]    quo_q;
  logic [tsc_pkg::DIV_W-1:0]     rem_q;
  logic [tsc_pkg::DIV_W-1:0]     dsr_q;
  logic [tsc_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [tsc_pkg::DIV_W-1:0]     rem_c [tsc_pkg::DIV_CELLS+1];
  logic [tsc_pkg::DIV_CELLS-1:0] qbits;

  assign rem_c[0] = rem_q;

  // remainder ripples from cell to cell; the last one feeds back next cycle
  for (genvar k = 0; k < tsc_pkg::DIV_CELLS; k++) begin : g_cell
    tsc_div_cell u_cell (
      .rem_i     (rem_c[k]),
      .bit_i     (dvd_q[tsc_pkg::DIVD_W-1-k]),
      .divisor_i (dsr_q),
      .rem_o     (rem_c[k+1]),
      .qbit_o    (qbits[tsc_pkg::DIV_CELLS-1-k])
    );
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = tsc_pkg::CNT_W'(tsc_pkg::DIV_STEPS);
    end else if (busy_q) begin
      cnt_d = cnt_q - tsc_pkg::CNT_W'(1);
      if (cnt_q == tsc_pkg::CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << tsc_pkg::DIV_CELLS;
      rem_q <= rem_c[tsc_pkg::DIV_CELLS];
      quo_q <= {quo_q[tsc_pkg::DIVD_W-tsc_pkg::DIV_CELLS-1:0], qbits};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: sv/taylor_sine_cosine.sv
// Taylor sine/cosine top level: Horner sequencer, shared multiplier, cell-chain divider.
//
// Input channel (in_valid_i/in_ready_o): kind_i (0 sine, 1 cosine) and angle_i, signed
// Q3.28 radians. Output channel (out_valid_o/out_ready_i): value_o, signed Q3.28 and
// clipped to 32 bits, with saturated_o set when clipping took place.
// Config channel (cfg_valid_i/cfg_ready_o/cfg_data_i): number of series terms N; 0 acts
// as 1, values above MAX_TERMS act as MAX_TERMS. Always ready; write it while idle.
// One item is worked on at a time. In each Horner step a 32x35 multiplier is used twice
// for the 62x35 product and the cell-chain divider retires 8 quotient bits a cycle over
// a 72-bit dividend. Sine adds a final product by x after the last step, before the
// result register. in_ready_o rises in the same cycle as out_valid_o, as the result is
// registered. The result register holds one item; while the receiver stalls, the next
// item is still taken and worked on, and then waits for the register to drain.
// Reset clears the sequencer and the output valid and sets N to 8.
`include "taylor_sine_cosine_macros.svh"

module taylor_sine_cosine #(
  parameter int MAX_TERMS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              kind_i,
  input  logic signed [tsc_pkg::ANGLE_W-1:0] angle_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tsc_pkg::ANGLE_W-1:0] value_o,
  output logic                              saturated_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tsc_pkg::TERMS_W-1:0]       cfg_data_i
);

  localparam int M_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  tsc_pkg::tsc_state_e state_q, state_d;

  logic [tsc_pkg::TERMS_W-1:0]  term_count_q;
  logic                         kind_q;
  logic                         xneg_q;
  logic [tsc_pkg::ANGLE_W-1:0]  ax_q;
  logic [tsc_pkg::XSQ_W-1:0]    xsq_q;
  logic [M_W-1:0]               m_q;
  logic                         fact_neg_q;
  logic signed [63:0]           acc_q;
  logic                         sneg_q;
  logic [tsc_pkg::MAG_W-1:0]    smag_q;
  logic [tsc_pkg::MUL_W-1:0]    mul_q;
  logic [tsc_pkg::PROD_W-1:0]   prod_q;
  logic                         out_valid_q, out_valid_d;
  logic signed [tsc_pkg::ANGLE_W-1:0] value_q;
  logic                         sat_q;

  logic [5:0]                   n_terms;
  logic [tsc_pkg::ANGLE_W-1:0]  angle_mag;
  logic signed [63:0]           s_sum;
  logic [63:0]                  s_mag;
  logic [tsc_pkg::ANGLE_W-1:0]  op_a;
  logic [tsc_pkg::XSQ_W-1:0]    op_b;
  logic [tsc_pkg::MUL_W-1:0]    mul_p;
  logic [tsc_pkg::MAG_W-1:0]    quo_cap;
  logic signed [63:0]           acc_next;
  logic [tsc_pkg::FIN_W-1:0]    fin_mag;
  logic                         fin_neg;
  logic [tsc_pkg::ANGLE_W-1:0]  fin_value;
  logic                         fin_sat;
  logic                         out_load;

  tsc_pkg::tsc_div_req_t div_req;
  tsc_pkg::tsc_div_rsp_t div_rsp;

  tsc_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // clamp the configured term count into 1 .. MAX_TERMS
  always_comb begin
    if (term_count_q == '0) begin
      n_terms = 6'd1;
    end else if (6'(term_count_q) > 6'(MAX_TERMS)) begin
      n_terms = 6'(MAX_TERMS);
    end else begin
      n_terms = 6'(term_count_q);
    end
  end

  assign angle_mag = angle_i[tsc_pkg::ANGLE_W-1] ? (~angle_i + 32'd1) : angle_i;

  // fact ends at +1 after the last flip, so this also forms 1 + acc
  assign s_sum = (fact_neg_q ? -tsc_pkg::ONE_Q : tsc_pkg::ONE_Q) + acc_q;
  assign s_mag = s_sum[63] ? (~s_sum + 64'd1) : s_sum;

  always_comb begin
    case (state_q)
      tsc_pkg::S_MLO: op_a = {1'b0, smag_q[tsc_pkg::HALF_W-1:0]};
      tsc_pkg::S_MHI: op_a = {1'b0, smag_q[tsc_pkg::MAG_W-1:tsc_pkg::HALF_W]};
      default:        op_a = ax_q;
    endcase
    if (state_q == tsc_pkg::S_SQ || m_q == '0) begin
      op_b = tsc_pkg::XSQ_W'(ax_q);
    end else begin
      op_b = xsq_q;
    end
  end

  assign mul_p = op_a * op_b;

  assign quo_cap  = (div_rsp.quotient > tsc_pkg::DIVD_W'(tsc_pkg::ACC_CAP))
                    ? tsc_pkg::ACC_CAP : div_rsp.quotient[tsc_pkg::MAG_W-1:0];
  assign acc_next = sneg_q ? -$signed({2'b00, quo_cap}) : $signed({2'b00, quo_cap});

  // final truncation to 32 bits with clipping
  always_comb begin
    fin_mag = kind_q ? tsc_pkg::FIN_W'(smag_q) : prod_q[tsc_pkg::PROD_W-1:tsc_pkg::FRAC_BITS];
    fin_neg = kind_q ? sneg_q : ((sneg_q != xneg_q) && (fin_mag != '0));
    if (fin_neg) begin
      fin_sat   = fin_mag > tsc_pkg::FIN_W'(tsc_pkg::NEG_MIN);
      fin_value = fin_sat ? tsc_pkg::NEG_MIN : (~fin_mag[tsc_pkg::ANGLE_W-1:0] + 32'd1);
    end else begin
      fin_sat   = fin_mag > tsc_pkg::FIN_W'(tsc_pkg::POS_MAX);
      fin_value = fin_sat ? tsc_pkg::POS_MAX : fin_mag[tsc_pkg::ANGLE_W-1:0];
    end
  end

  always_comb begin
    state_d          = state_q;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = tsc_pkg::DIVD_W'(prod_q[tsc_pkg::PROD_W-1:tsc_pkg::FRAC_BITS]);
    div_req.divisor  = tsc_pkg::div_const(kind_q, tsc_pkg::TERMS_W'(m_q));
    case (state_q)
      tsc_pkg::S_IDLE: begin
        if (in_valid_i) state_d = tsc_pkg::S_SQ;
      end
      tsc_pkg::S_SQ:   state_d = tsc_pkg::S_SQ_W;
      tsc_pkg::S_SQ_W: state_d = tsc_pkg::S_PREP;
      tsc_pkg::S_PREP: begin
        if (m_q == '0 && kind_q) state_d = tsc_pkg::S_OUT;
        else                     state_d = tsc_pkg::S_MLO;
      end
      tsc_pkg::S_MLO:  state_d = tsc_pkg::S_MHI;
      tsc_pkg::S_MHI:  state_d = tsc_pkg::S_MADD;
      tsc_pkg::S_MADD: begin
        if (m_q == '0) state_d = tsc_pkg::S_OUT;
        else           state_d = tsc_pkg::S_DIV_GO;
      end
      tsc_pkg::S_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = tsc_pkg::S_DIV_WAIT;
      end
      tsc_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) state_d = tsc_pkg::S_PREP;
      end
      tsc_pkg::S_OUT: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tsc_pkg::S_IDLE;
        end
      end
      default: state_d = tsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (out_load)                   out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tsc_pkg::S_IDLE;
      term_count_q <= tsc_pkg::TERMS_RESET;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) term_count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_p;
    case (state_q)
      tsc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_q     <= kind_i;
          xneg_q     <= angle_i[tsc_pkg::ANGLE_W-1];
          ax_q       <= angle_mag;
          m_q        <= M_W'(n_terms - 6'd1);
          fact_neg_q <= ~n_terms[0];
          acc_q      <= '0;
        end
      end
      tsc_pkg::S_SQ_W: xsq_q <= mul_q[tsc_pkg::FRAC_BITS +: tsc_pkg::XSQ_W];
      tsc_pkg::S_PREP: begin
        smag_q <= s_mag[tsc_pkg::MAG_W-1:0];
        sneg_q <= s_sum[63];
      end
      tsc_pkg::S_MHI:  prod_q <= tsc_pkg::PROD_W'(mul_q);
      tsc_pkg::S_MADD: prod_q <= prod_q + (tsc_pkg::PROD_W'(mul_q) << tsc_pkg::HALF_W);
      tsc_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          acc_q      <= acc_next;
          fact_neg_q <= ~fact_neg_q;
          m_q        <= m_q - M_W'(1);
        end
      end
      tsc_pkg::S_OUT: begin
        if (out_load) begin
          value_q <= $signed(fin_value);
          sat_q   <= fin_sat;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == tsc_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign saturated_o = sat_q;
  assign cfg_ready_o = 1'b1;

  `TSC_ASSERT(a_ready_div_idle, in_ready_o |-> !div_rsp.busy, "divider busy while idle")
  `TSC_ASSERT(a_start_when_free, div_req.start |-> !div_rsp.busy, "divider restarted mid-run")
  `TSC_ASSERT(a_done_in_wait, div_rsp.done |-> state_q == tsc_pkg::S_DIV_WAIT, "stray divider done")
  `TSC_ASSERT_NEVER(a_acc_bound, (state_q == tsc_pkg::S_PREP) && ((acc_q > tsc_pkg::ACC_LIM) || (acc_q < -tsc_pkg::ACC_LIM)), "accumulator past cap")

endmodule
